>>> hw/rtl/hbp_pkg.sv
`default_nettype none

package hbp_pkg;

   localparam int CODE_WIDTH = 32;
   localparam int LEN_WIDTH = 6;
   localparam int ACC_WIDTH = 40;

   localparam logic [1:0] KIND_LOAD = 2'd0;
   localparam logic [1:0] KIND_ENCODE = 2'd1;
   localparam logic [1:0] KIND_FLUSH = 2'd2;

   typedef struct packed {
      logic [1:0]            kind;
      logic [7:0]            symbol;
      logic [CODE_WIDTH-1:0] code_bits;
      logic [LEN_WIDTH-1:0]  code_length;
   } req_type;

   typedef struct packed {
      logic [7:0] packed_byte;
      logic [3:0] bit_count;
      logic       status;
      logic       last_of_run;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SHIFT,
      ST_ERR,
      ST_FLUSH
   } state_type;

endpackage

`default_nettype wire

>>> hw/rtl/huffman_bit_packer.sv
// Huffman bit packer with a loadable code table.
// Items arrive on the req_ channel (valid/stall) as req_type: a load item writes
// one symbol's code and length if both are in range, an encode item appends the
// symbol's code to the byte accumulator, and a flush item emits any pending partial byte.
// Results leave on the rsp_ channel as rsp_type, one per cycle at most; the last
// result caused by an item carries last_of_run.
// The block handles one item at a time and stalls the input meanwhile. A load
// is done while idle. An encode reads the table, then aligns the code behind the
// pending bits, then takes one shift step per completed byte through the single
// accumulator shifter. An absent symbol returns an error result; a flush returns
// the pending bits as one result.
// Reset clears all table valid marks at once, the pending bits and the output valid.
// When the receiver stalls, the output register holds its item and the shift
// sequence waits until the register is free again.
`default_nettype none

module huffman_bit_packer
   import hbp_pkg::*;
#(
   parameter int SYMBOL_COUNT = 256,
   parameter int MAX_CODE_LEN = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   localparam int AddrWidth = $clog2(SYMBOL_COUNT);
   localparam int LenLimit = (MAX_CODE_LEN < CODE_WIDTH) ? MAX_CODE_LEN : CODE_WIDTH;
   localparam int RamWidth = CODE_WIDTH + LEN_WIDTH;

   state_type                 state_ff, state_in;
   logic [SYMBOL_COUNT-1:0]   valid_ff, valid_in;
   logic [7:0]                pend_byte_ff, pend_byte_in;
   logic [2:0]                pend_count_ff, pend_count_in;
   logic [ACC_WIDTH-1:0]      acc_ff, acc_in;
   logic [LEN_WIDTH-1:0]      nbits_ff, nbits_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   logic                      wr_en;
   logic                      rd_en;
   logic [AddrWidth-1:0]      sym_idx;
   logic                      sym_in_range;
   logic [RamWidth-1:0]       rd_data;
   logic [CODE_WIDTH-1:0]     rd_code;
   logic [LEN_WIDTH-1:0]      rd_len;
   logic [ACC_WIDTH-1:0]      code_mask;
   logic [ACC_WIDTH-1:0]      code_wide;
   logic [LEN_WIDTH-1:0]      total_bits;
   logic                      out_free;

   hbp_ram #(
      .WIDTH(RamWidth),
      .DEPTH(SYMBOL_COUNT)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(sym_idx),
      .wr_data({req_payload.code_bits, req_payload.code_length}),
      .rd_en  (rd_en),
      .rd_addr(sym_idx),
      .rd_data(rd_data)
   );

   assign sym_idx = req_payload.symbol[AddrWidth-1:0];
   assign sym_in_range = ({1'b0, req_payload.symbol} < 9'(SYMBOL_COUNT));
   assign rd_code = rd_data[RamWidth-1:LEN_WIDTH];
   assign rd_len = rd_data[LEN_WIDTH-1:0];
   assign code_mask = (ACC_WIDTH'(1) << rd_len) - ACC_WIDTH'(1);
   assign code_wide = ACC_WIDTH'(rd_code) & code_mask;
   assign total_bits = LEN_WIDTH'(pend_count_ff) + rd_len;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         pend_byte_ff <= '0;
         pend_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         pend_byte_ff <= pend_byte_in;
         pend_count_ff <= pend_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff <= acc_in;
      nbits_ff <= nbits_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      pend_byte_in = pend_byte_ff;
      pend_count_in = pend_count_ff;
      acc_in = acc_ff;
      nbits_in = nbits_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      wr_en = 1'b0;
      rd_en = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_payload.kind)
                  KIND_LOAD: begin
                     if (sym_in_range && (req_payload.code_length <= LEN_WIDTH'(LenLimit))) begin
                        wr_en = 1'b1;
                        valid_in[sym_idx] = 1'b1;
                     end
                  end
                  KIND_ENCODE: begin
                     if (sym_in_range && valid_ff[sym_idx]) begin
                        rd_en = 1'b1;
                        state_in = ST_READ;
                     end else begin
                        state_in = ST_ERR;
                     end
                  end
                  KIND_FLUSH: begin
                     if (pend_count_ff != 3'd0) begin
                        state_in = ST_FLUSH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            acc_in = {pend_byte_ff, 32'd0} | (code_wide << (LEN_WIDTH'(ACC_WIDTH) - total_bits));
            nbits_in = total_bits;
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (nbits_ff >= LEN_WIDTH'(8)) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in.packed_byte = acc_ff[ACC_WIDTH-1 -: 8];
                  rsp_data_in.bit_count = 4'd8;
                  rsp_data_in.status = 1'b0;
                  rsp_data_in.last_of_run = (nbits_ff < LEN_WIDTH'(16));
                  acc_in = acc_ff << 8;
                  nbits_in = nbits_ff - LEN_WIDTH'(8);
               end
            end else begin
               pend_byte_in = acc_ff[ACC_WIDTH-1 -: 8];
               pend_count_in = nbits_ff[2:0];
               state_in = ST_IDLE;
            end
         end
         ST_ERR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.packed_byte = 8'd0;
               rsp_data_in.bit_count = 4'd0;
               rsp_data_in.status = 1'b1;
               rsp_data_in.last_of_run = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.packed_byte = pend_byte_ff;
               rsp_data_in.bit_count = {1'b0, pend_count_ff};
               rsp_data_in.status = 1'b0;
               rsp_data_in.last_of_run = 1'b1;
               pend_byte_in = 8'd0;
               pend_count_in = 3'd0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hw/rtl/hbp_ram.sv
`default_nettype none

module hbp_ram #(
   parameter int WIDTH = 38,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> tb/sv/tb_huffman_bit_packer.sv
`timescale 1ns / 1ps

module tb_huffman_bit_packer;
   import hbp_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 270;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   class packed_byte_tracker;
      rsp_type expected_bytes[$];
      logic [CODE_WIDTH-1:0] code_mem[256];
      logic [LEN_WIDTH-1:0] len_mem[256];
      bit entry_ok[256];
      bit [7:0] pend_byte;
      int unsigned pend_cnt;
      int fault_count;

      function void queue_result(rsp_type res);
         expected_bytes = {expected_bytes, res};
      endfunction

      function void absorb_item(req_type item);
         bit [63:0] acc;
         bit [63:0] code;
         int unsigned clen;
         int unsigned nbits;
         rsp_type res;
         case (item.kind)
            KIND_LOAD: begin
               if (item.code_length <= CODE_WIDTH) begin
                  code_mem[item.symbol] = item.code_bits;
                  len_mem[item.symbol] = item.code_length;
                  entry_ok[item.symbol] = 1'b1;
               end
            end
            KIND_ENCODE: begin
               if (!entry_ok[item.symbol]) begin
                  res = '{8'd0, 4'd0, 1'b1, 1'b1};
                  queue_result(res);
               end else begin
                  clen = len_mem[item.symbol];
                  code = 64'(code_mem[item.symbol]) & ((64'd1 << clen) - 64'd1);
                  acc = (64'(pend_byte) >> (8 - pend_cnt)) << clen;
                  acc = acc | code;
                  nbits = pend_cnt + clen;
                  while (nbits >= 8) begin
                     nbits = nbits - 8;
                     res.packed_byte = acc[nbits +: 8];
                     res.bit_count = 4'd8;
                     res.status = 1'b0;
                     res.last_of_run = (nbits < 8);
                     queue_result(res);
                  end
                  acc = acc & ((64'd1 << nbits) - 64'd1);
                  pend_byte = 8'(acc << (8 - nbits));
                  pend_cnt = nbits;
               end
            end
            KIND_FLUSH: begin
               if (pend_cnt != 0) begin
                  res = '{pend_byte, 4'(pend_cnt), 1'b0, 1'b1};
                  queue_result(res);
                  pend_byte = 8'd0;
                  pend_cnt = 0;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_reply(rsp_type got);
         rsp_type want;
         if (expected_bytes.size() == 0) begin
            if (fault_count < 10)
               $display("unexpected result: byte %02h count %0d status %0b last %0b",
                        got.packed_byte, got.bit_count, got.status, got.last_of_run);
            fault_count++;
            return;
         end
         want = expected_bytes.pop_front();
         if (got.packed_byte !== want.packed_byte || got.bit_count !== want.bit_count ||
             got.status !== want.status || got.last_of_run !== want.last_of_run) begin
            if (fault_count < 10)
               $display("mismatch: expected byte %02h count %0d status %0b last %0b",
                        want.packed_byte, want.bit_count, want.status, want.last_of_run,
                        ", got byte %02h count %0d status %0b last %0b",
                        got.packed_byte, got.bit_count, got.status, got.last_of_run);
            fault_count++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_payload;

   packed_byte_tracker tracker = new;
   bit send_gaps = 1'b1;
   bit reply_stalls = 1'b1;
   int stall_left = 0;
   logic [7:0] loaded_syms[$];

   huffman_bit_packer dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function req_type build_item(logic [1:0] kind, logic [7:0] symbol,
                                logic [31:0] bits, logic [5:0] len);
      req_type item;
      item.kind = kind;
      item.symbol = symbol;
      item.code_bits = bits;
      item.code_length = len;
      return item;
   endfunction

   function req_type random_item();
      req_type item;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      item.code_bits = $urandom;
      item.symbol = 8'($urandom);
      item.code_length = 6'($urandom_range(0, 12));
      if (pick < 22) begin
         item.kind = KIND_LOAD;
         if ($urandom_range(0, 9) == 0)
            item.code_length = 6'($urandom_range(13, 32));
         else if ($urandom_range(0, 9) == 0)
            item.code_length = 6'($urandom_range(33, 63));
      end else if (pick < 85) begin
         item.kind = KIND_ENCODE;
         if (loaded_syms.size() != 0 && $urandom_range(0, 9) != 0)
            item.symbol = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
      end else if (pick < 96) begin
         item.kind = KIND_FLUSH;
      end else begin
         item.kind = KIND_UNUSED;
      end
      return item;
   endfunction

   task send_item(input req_type item);
      if (send_gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.absorb_item(item);
      if (item.kind == KIND_LOAD && item.code_length <= CODE_WIDTH)
         loaded_syms = {loaded_syms, item.symbol};
   endtask

   task wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_bytes.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            tracker.check_reply(rsp_payload);
         if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (reply_stalls && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 5);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAIL huffman_bit_packer");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_item(build_item(KIND_FLUSH, 8'd0, 32'd0, 6'd0));
      send_item(build_item(KIND_ENCODE, 8'd0, 32'd0, 6'd0));
      send_item(build_item(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F));
      send_item(build_item(KIND_LOAD, 8'd0, 32'h0000_0001, 6'd1));
      send_item(build_item(KIND_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32));
      send_item(build_item(KIND_LOAD, 8'd1, 32'hFFFF_FFFF, 6'd0));
      send_item(build_item(KIND_LOAD, 8'd3, 32'hDEAD_BEA5, 6'd8));
      send_item(build_item(KIND_LOAD, 8'd4, 32'h0000_0000, 6'd33));
      send_item(build_item(KIND_LOAD, 8'd2, 32'h0000_0000, 6'd32));
      send_item(build_item(KIND_LOAD, 8'd5, 32'h0000_0005, 6'd3));
      send_item(build_item(KIND_LOAD, 8'd5, 32'hFFFF_FFFF, 6'd63));
      send_item(build_item(KIND_ENCODE, 8'd0, 32'd0, 6'd0));
      send_item(build_item(KIND_ENCODE, 8'hFF, 32'd0, 6'd0));
      send_item(build_item(KIND_ENCODE, 8'd1, 32'd0, 6'd0));
      send_item(build_item(KIND_ENCODE, 8'd4, 32'd0, 6'd0));
      send_item(build_item(KIND_ENCODE, 8'd3, 32'd0, 6'd0));
      send_item(build_item(KIND_ENCODE, 8'd2, 32'd0, 6'd0));
      send_item(build_item(KIND_ENCODE, 8'd5, 32'd0, 6'd0));
      send_item(build_item(KIND_FLUSH, 8'd0, 32'd0, 6'd0));
      send_item(build_item(KIND_FLUSH, 8'd0, 32'd0, 6'd0));
      send_item(build_item(KIND_ENCODE, 8'hFF, 32'd0, 6'd0));
      send_item(build_item(KIND_FLUSH, 8'd0, 32'd0, 6'd0));
      send_item(build_item(KIND_ENCODE, 8'd5, 32'd0, 6'd0));
      send_item(build_item(KIND_ENCODE, 8'd7, 32'd0, 6'd0));
      send_item(build_item(KIND_FLUSH, 8'd0, 32'd0, 6'd0));
      wait_for_drain();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 30 == 0) begin
            send_gaps = ($urandom_range(0, 2) != 0);
            reply_stalls = ($urandom_range(0, 2) != 0);
         end
         if (i >= RANDOM_ITEMS - 40) begin
            send_gaps = 1'b0;
            reply_stalls = 1'b0;
         end
         if (i == RANDOM_ITEMS / 2)
            wait_for_drain();
         send_item(random_item());
      end

      wait_for_drain();
      repeat (16) @(posedge clock);
      if (tracker.fault_count == 0 && tracker.expected_bytes.size() == 0)
         $display("PASS huffman_bit_packer");
      else
         $display("FAIL huffman_bit_packer");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/hbp_pkg.sv
hw/rtl/hbp_ram.sv
hw/rtl/huffman_bit_packer.sv
tb/sv/tb_huffman_bit_packer.sv
